>>> sv/odo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_pkg
// Shared widths, constants, handshake structs and helper functions for the
// differential drive odometry core.
// ----------------------------------------------------------------------------
package odo_pkg;

	localparam int CNT_W    = 16;
	localparam int PERIOD_W = 20;
	localparam int RATE_W   = 32;
	localparam int HEAD_W   = 40;
	localparam int POS_W    = 48;
	localparam int DLT_W    = 18;
	localparam int ANG_W    = 28;
	localparam int CS_W     = 34;

	localparam int CORDIC_STEPS_DEF = 24;

	// register indexes on the configuration port
	localparam logic [1:0] REG_CPT   = 2'd0;
	localparam logic [1:0] REG_TIRE  = 2'd1;
	localparam logic [1:0] REG_TRACK = 2'd2;

	localparam logic [CNT_W-1:0] CPT_RST   = 16'd16384;
	localparam logic [CNT_W-1:0] TIRE_RST  = 16'd3456;
	localparam logic [CNT_W-1:0] TRACK_RST = 16'd8448;

	// round(2*pi*1e6*2^16)
	localparam logic [63:0] K_RATE     = 64'd411774832291;
	localparam logic [63:0] MUL_LIMIT  = 64'h4000_0000_0000_0000;
	localparam logic [63:0] SPEED_DIV  = 64'd131072;
	localparam logic [63:0] HEAD_SCALE = 64'd16777216;
	localparam logic [63:0] MICRO      = 64'd1000000;
	localparam logic [63:0] Q30_ONE    = 64'd1073741824;
	localparam logic [19:0] MICRO_20   = 20'd1000000;

	localparam logic [ANG_W-1:0] HALF_PI_Q25 = 28'd52707179;
	localparam logic [ANG_W-1:0] PI_Q25      = 28'd105414358;
	localparam logic [ANG_W-1:0] PI3_2_Q25   = 28'd158121537;
	localparam logic [ANG_W-1:0] TWO_PI_Q25  = 28'd210828716;

	localparam logic signed [CS_W-1:0] GAIN_Q30   = 34'sd652032875;
	localparam logic signed [63:0]     SMALL_TURN = 64'sd131072;

	typedef struct packed {
		logic              start;
		logic              rnd;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] c;
	} md_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic signed [63:0] quot;
		logic [63:0]        rem;
	} md_rsp_t;

	typedef struct packed {
		logic             start;
		logic [ANG_W-1:0] ang;
	} cor_req_t;

	typedef struct packed {
		logic                   busy;
		logic                   done;
		logic signed [CS_W-1:0] co;
		logic signed [CS_W-1:0] si;
	} cor_rsp_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd843314857;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043837;
			5'd3:  r = 30'd133525159;
			5'd4:  r = 30'd67021687;
			5'd5:  r = 30'd33543516;
			5'd6:  r = 30'd16775851;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194283;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			5'd24: r = 30'd64;
			5'd25: r = 30'd32;
			5'd26: r = 30'd16;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			5'd30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [RATE_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [RATE_W-1:0] r;
		if (v[63:RATE_W-1] == '0 || v[63:RATE_W-1] == '1)
			r = v[RATE_W-1:0];
		else
			r = v[63] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [HEAD_W-1:0] sat40(input logic signed [64:0] v);
		logic signed [HEAD_W-1:0] r;
		if (v[64:HEAD_W-1] == '0 || v[64:HEAD_W-1] == '1)
			r = v[HEAD_W-1:0];
		else
			r = v[64] ? {1'b1, {(HEAD_W-1){1'b0}}} : {1'b0, {(HEAD_W-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] sat48(input logic signed [64:0] v);
		logic signed [POS_W-1:0] r;
		if (v[64:POS_W-1] == '0 || v[64:POS_W-1] == '1)
			r = v[POS_W-1:0];
		else
			r = v[64] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		return r;
	endfunction

	// count change with wrap folding around half a turn
	function automatic logic signed [DLT_W-1:0] unwrap(input logic [CNT_W-1:0] cur,
			input logic [CNT_W-1:0] prev, input logic [CNT_W-1:0] cpt);
		logic signed [DLT_W-1:0] d;
		logic signed [DLT_W-1:0] half;
		logic signed [DLT_W-1:0] full;
		d    = signed'({2'b00, cur}) - signed'({2'b00, prev});
		half = signed'({3'b000, cpt[CNT_W-1:1]});
		full = signed'({2'b00, cpt});
		if (cpt >= 16'd2) begin
			if (d >= half)
				d = d - full;
			else if (d <= -half)
				d = d + full;
		end
		return d;
	endfunction

endpackage

>>> sv/odo_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_muldiv
// Bit-serial signed a*b/c, rounded if rnd is set: shift-add multiply then
// restoring divide, one bit per cycle. Returns the remainder for angle reduction.
// ----------------------------------------------------------------------------
module odo_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  odo_pkg::md_req_t req,
	output odo_pkg::md_rsp_t rsp
);

	typedef enum logic [2:0] {M_IDLE, M_MUL, M_RND, M_CHK, M_DIV, M_FIN} mstate_t;

	mstate_t            state_q;
	logic [63:0]        a_q;
	logic [63:0]        c_q;
	logic [63:0]        hi_q;
	logic [63:0]        lo_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic               rnd_q;
	logic               sat_q;
	logic               done_q;
	logic signed [63:0] quot_q;
	logic [63:0]        rem_q;

	logic [64:0] madd;
	logic [64:0] lo_rnd;
	logic [64:0] dtry;
	logic [64:0] dsub;
	logic [63:0] qmag;

	always_comb begin
		madd   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 65'd0);
		lo_rnd = {1'b0, lo_q} + {2'b00, c_q[63:1]};
		dtry   = {hi_q, lo_q[63]};
		dsub   = dtry - {1'b0, c_q};
		qmag   = sat_q ? odo_pkg::MUL_LIMIT :
			((lo_q > odo_pkg::MUL_LIMIT) ? odo_pkg::MUL_LIMIT : lo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_q     <= odo_pkg::mag64(req.a);
						lo_q    <= odo_pkg::mag64(req.b);
						c_q     <= odo_pkg::mag64(req.c);
						hi_q    <= '0;
						neg_q   <= req.a[63] ^ req.b[63] ^ req.c[63];
						rnd_q   <= req.rnd;
						sat_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					hi_q  <= madd[64:1];
					lo_q  <= {madd[0], lo_q[63:1]};
					cnt_q <= cnt_q + 6'd1;
					if (&cnt_q)
						state_q <= M_RND;
				end
				M_RND: begin
					if (rnd_q) begin
						lo_q <= lo_rnd[63:0];
						hi_q <= hi_q + {63'd0, lo_rnd[64]};
					end
					state_q <= M_CHK;
				end
				M_CHK: begin
					// quotient would not fit in 64 bits
					if (hi_q >= c_q) begin
						sat_q   <= 1'b1;
						state_q <= M_FIN;
					end else begin
						state_q <= M_DIV;
					end
				end
				M_DIV: begin
					if (dtry >= {1'b0, c_q}) begin
						hi_q <= dsub[63:0];
						lo_q <= {lo_q[62:0], 1'b1};
					end else begin
						hi_q <= dtry[63:0];
						lo_q <= {lo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (&cnt_q)
						state_q <= M_FIN;
				end
				M_FIN: begin
					quot_q  <= neg_q ? -signed'(qmag) : signed'(qmag);
					rem_q   <= hi_q;
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.busy = (state_q != M_IDLE);
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

>>> sv/odo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation-mode CORDIC: sine and cosine in Q30 of a reduced angle
// in [0, 2*pi) at 2^-25 rad, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module odo_cordic #(
	parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  odo_pkg::cor_req_t req,
	output odo_pkg::cor_rsp_t rsp
);

	localparam int CW = $clog2(CORDIC_STEPS + 1);

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

	cstate_t                         state_q;
	logic signed [odo_pkg::CS_W-1:0] x_q;
	logic signed [odo_pkg::CS_W-1:0] y_q;
	logic signed [odo_pkg::CS_W-1:0] z_q;
	logic [CW-1:0]                   cnt_q;
	logic [1:0]                      quad_q;
	logic                            done_q;
	logic signed [odo_pkg::CS_W-1:0] co_q;
	logic signed [odo_pkg::CS_W-1:0] si_q;

	logic [1:0]                      quad;
	logic [odo_pkg::ANG_W-1:0]       base;
	logic [odo_pkg::ANG_W-1:0]       frac;
	logic signed [odo_pkg::CS_W-1:0] z0;
	logic signed [odo_pkg::CS_W-1:0] xsh;
	logic signed [odo_pkg::CS_W-1:0] ysh;
	logic signed [odo_pkg::CS_W-1:0] at;

	always_comb begin
		if (req.ang >= odo_pkg::PI3_2_Q25) begin
			quad = 2'd3;
			base = odo_pkg::PI3_2_Q25;
		end else if (req.ang >= odo_pkg::PI_Q25) begin
			quad = 2'd2;
			base = odo_pkg::PI_Q25;
		end else if (req.ang >= odo_pkg::HALF_PI_Q25) begin
			quad = 2'd1;
			base = odo_pkg::HALF_PI_Q25;
		end else begin
			quad = 2'd0;
			base = '0;
		end
		frac = req.ang - base;
		// Q25 -> Q30
		z0   = signed'({1'b0, frac, 5'b00000});
		xsh  = x_q >>> cnt_q;
		ysh  = y_q >>> cnt_q;
		at   = signed'({4'b0000, odo_pkg::atan_q30(5'(cnt_q))});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (req.start) begin
						x_q     <= odo_pkg::GAIN_Q30;
						y_q     <= '0;
						z_q     <= z0;
						quad_q  <= quad;
						cnt_q   <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (!z_q[odo_pkg::CS_W-1]) begin
						x_q <= x_q - ysh;
						y_q <= y_q + xsh;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + ysh;
						y_q <= y_q - xsh;
						z_q <= z_q + at;
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(CORDIC_STEPS - 1))
						state_q <= C_FIN;
				end
				C_FIN: begin
					case (quad_q)
						2'd0: begin
							co_q <= x_q;
							si_q <= y_q;
						end
						2'd1: begin
							co_q <= -y_q;
							si_q <= x_q;
						end
						2'd2: begin
							co_q <= -x_q;
							si_q <= -y_q;
						end
						default: begin
							co_q <= y_q;
							si_q <= -x_q;
						end
					endcase
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign rsp.busy = (state_q != C_IDLE);
	assign rsp.done = done_q;
	assign rsp.co   = co_q;
	assign rsp.si   = si_q;

endmodule

>>> sv/differential_drive_odometry_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Wheel odometry for a differential drive: wheel rates, wheel speeds,
// heading and x,y pose from two absolute encoder counts per sample.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid/in_ready) carries one encoder sample per
//   transaction; output channel (out_valid/out_ready) returns one pose per
//   sample. Configuration writes (cfg_we, cfg_index, cfg_data) take effect
//   at once and belong in idle periods.
// - One sample is in flight at a time. Its work runs as a chain of passes
//   through one bit-serial multiply-divide unit (9 passes on a straight step,
//   11 on a curve; a pass skips its divide when the quotient saturates) and
//   one or two CORDIC runs. A zero period or count setting skips the two
//   rate passes.
// - in_ready is high while the sequencer is idle. A finished pose sits in
//   the output register; a new sample is taken while it waits, and that
//   sample's pose is held back until the receiver takes the previous one.
// - Reset loads the default geometry, clears the pose and marks the next
//   sample as the first one. A sample with restart set does the same for
//   the pose and reports zero rates.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core #(
	parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [odo_pkg::CNT_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [odo_pkg::CNT_W-1:0]           left_count,
	input  logic [odo_pkg::CNT_W-1:0]           right_count,
	input  logic [odo_pkg::PERIOD_W-1:0]        period_us,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [odo_pkg::RATE_W-1:0]   left_wheel_rate,
	output logic signed [odo_pkg::RATE_W-1:0]   right_wheel_rate,
	output logic signed [odo_pkg::RATE_W-1:0]   left_speed,
	output logic signed [odo_pkg::RATE_W-1:0]   right_speed,
	output logic signed [odo_pkg::HEAD_W-1:0]   heading,
	output logic signed [odo_pkg::POS_W-1:0]    pos_x,
	output logic signed [odo_pkg::POS_W-1:0]    pos_y
);

	typedef enum logic [4:0] {
		S_IDLE, S_PREP, S_RL, S_RR, S_VL, S_VR, S_DIFF, S_DTH, S_HEAD, S_S,
		S_MOD1, S_COR1, S_A, S_MOD2, S_COR2, S_X, S_Y, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [odo_pkg::CNT_W-1:0] cpt_q;
	logic [odo_pkg::CNT_W-1:0] tire_q;
	logic [odo_pkg::CNT_W-1:0] track_q;

	// captured sample
	logic [odo_pkg::CNT_W-1:0]    lc_q;
	logic [odo_pkg::CNT_W-1:0]    rraw_q;
	logic [odo_pkg::PERIOD_W-1:0] period_q;
	logic                         rst_q;

	// persistent state
	logic                              first_q;
	logic [odo_pkg::CNT_W-1:0]         prev_l_q;
	logic [odo_pkg::CNT_W-1:0]         prev_r_q;
	logic signed [odo_pkg::HEAD_W-1:0] head_q;
	logic signed [odo_pkg::POS_W-1:0]  x_q;
	logic signed [odo_pkg::POS_W-1:0]  y_q;

	// working registers
	logic signed [odo_pkg::DLT_W-1:0]  dl_q;
	logic signed [odo_pkg::DLT_W-1:0]  dr_q;
	logic [35:0]                       den_q;
	logic signed [odo_pkg::RATE_W-1:0] rl_q;
	logic signed [odo_pkg::RATE_W-1:0] rr_q;
	logic signed [odo_pkg::RATE_W-1:0] vl_q;
	logic signed [odo_pkg::RATE_W-1:0] vr_q;
	logic signed [53:0]                prod_q;
	logic [35:0]                       tden_q;
	logic signed [63:0]                dth_q;
	logic signed [odo_pkg::HEAD_W-1:0] hnew_q;
	logic signed [63:0]                s_q;
	logic signed [63:0]                a_q;
	logic [odo_pkg::ANG_W-1:0]         r_q;
	logic signed [odo_pkg::CS_W-1:0]   co_q;
	logic signed [odo_pkg::CS_W-1:0]   si_q;
	logic                              issued_q;

	// output register
	logic                              out_valid_q;
	logic signed [odo_pkg::RATE_W-1:0] o_rl_q;
	logic signed [odo_pkg::RATE_W-1:0] o_rr_q;
	logic signed [odo_pkg::RATE_W-1:0] o_vl_q;
	logic signed [odo_pkg::RATE_W-1:0] o_vr_q;
	logic signed [odo_pkg::HEAD_W-1:0] o_head_q;
	logic signed [odo_pkg::POS_W-1:0]  o_x_q;
	logic signed [odo_pkg::POS_W-1:0]  o_y_q;

	odo_pkg::md_req_t  md_req;
	odo_pkg::md_rsp_t  md_rsp;
	odo_pkg::cor_req_t cor_req;
	odo_pkg::cor_rsp_t cor_rsp;

	logic [odo_pkg::CNT_W-1:0]        rc;
	logic                             first_eff;
	logic [odo_pkg::CNT_W-1:0]        pl;
	logic [odo_pkg::CNT_W-1:0]        pr;
	logic [35:0]                      den_w;
	logic [35:0]                      tden_w;
	logic signed [32:0]               vdiff;
	logic signed [32:0]               vsum;
	logic signed [20:0]               per_s;
	logic signed [53:0]               prod_w;
	logic signed [64:0]               hsum;
	logic signed [63:0]               ang2;
	logic signed [64:0]               xsum;
	logic signed [64:0]               ysum;
	logic                             md_go;
	logic                             mod_neg;
	logic [odo_pkg::ANG_W-1:0]        rem28;
	logic [odo_pkg::ANG_W-1:0]        red;
	logic                             big_turn;
	logic                             out_load;

	always_comb begin
		rc        = (rraw_q == '0) ? '0 : odo_pkg::CNT_W'(cpt_q - rraw_q);
		first_eff = first_q | rst_q;
		pl        = first_eff ? lc_q : prev_l_q;
		pr        = first_eff ? rc : prev_r_q;
		den_w     = 36'(cpt_q) * 36'(period_q);
		tden_w    = 36'(track_q) * 36'(odo_pkg::MICRO_20);
		vdiff     = 33'(vl_q) - 33'(vr_q);
		vsum      = 33'(vl_q) + 33'(vr_q);
		per_s     = signed'({1'b0, period_q});
		prod_w    = vdiff * per_s;
		hsum      = 65'(head_q) + 65'(dth_q);
		ang2      = 64'(head_q) + 64'(hnew_q);
		xsum      = 65'(x_q) + 65'(md_rsp.quot);
		ysum      = 65'(y_q) + 65'(md_rsp.quot);
		big_turn  = (dth_q >= odo_pkg::SMALL_TURN) || (dth_q <= -odo_pkg::SMALL_TURN);
		mod_neg   = (state_q == S_MOD1) ? dth_q[63] : ang2[63];
		rem28     = md_rsp.rem[odo_pkg::ANG_W-1:0];
		// C-style remainder folded into [0, 2*pi)
		red       = (mod_neg && rem28 != '0) ? odo_pkg::TWO_PI_Q25 - rem28 : rem28;
		out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	// operand select for the shared multiply-divide unit
	always_comb begin
		md_go      = 1'b0;
		md_req.rnd = 1'b1;
		md_req.a   = '0;
		md_req.b   = '0;
		md_req.c   = '0;
		case (state_q)
			S_RL: begin
				md_go    = (den_q != '0);
				md_req.a = 64'(dl_q);
				md_req.b = signed'(odo_pkg::K_RATE);
				md_req.c = signed'(64'(den_q));
			end
			S_RR: begin
				md_go    = 1'b1;
				md_req.a = 64'(dr_q);
				md_req.b = signed'(odo_pkg::K_RATE);
				md_req.c = signed'(64'(den_q));
			end
			S_VL: begin
				md_go    = 1'b1;
				md_req.a = 64'(rl_q);
				md_req.b = signed'(64'(tire_q));
				md_req.c = signed'(odo_pkg::SPEED_DIV);
			end
			S_VR: begin
				md_go    = 1'b1;
				md_req.a = 64'(rr_q);
				md_req.b = signed'(64'(tire_q));
				md_req.c = signed'(odo_pkg::SPEED_DIV);
			end
			S_DTH: begin
				md_go    = (track_q != '0);
				md_req.a = 64'(prod_q);
				md_req.b = signed'(odo_pkg::HEAD_SCALE);
				md_req.c = signed'(64'(tden_q));
			end
			S_S: begin
				md_go    = 1'b1;
				md_req.a = 64'(vsum);
				md_req.b = signed'(64'({period_q, 3'b000}));
				md_req.c = signed'(odo_pkg::MICRO);
			end
			S_MOD1: begin
				md_go      = 1'b1;
				md_req.rnd = 1'b0;
				md_req.a   = dth_q;
				md_req.b   = 64'sd1;
				md_req.c   = signed'(64'(odo_pkg::TWO_PI_Q25));
			end
			S_A: begin
				md_go    = 1'b1;
				md_req.a = s_q;
				md_req.b = 64'(si_q);
				md_req.c = dth_q <<< 5;
			end
			S_MOD2: begin
				md_go      = 1'b1;
				md_req.rnd = 1'b0;
				md_req.a   = ang2;
				md_req.b   = 64'sd1;
				md_req.c   = signed'(64'(odo_pkg::TWO_PI_Q25));
			end
			S_X: begin
				md_go    = 1'b1;
				md_req.a = a_q;
				md_req.b = 64'(co_q);
				md_req.c = signed'(odo_pkg::Q30_ONE);
			end
			S_Y: begin
				md_go    = 1'b1;
				md_req.a = a_q;
				md_req.b = 64'(si_q);
				md_req.c = signed'(odo_pkg::Q30_ONE);
			end
			default: md_go = 1'b0;
		endcase
		md_req.start  = md_go && !issued_q;
		cor_req.start = (state_q == S_COR1 || state_q == S_COR2) && !issued_q;
		cor_req.ang   = r_q;
	end

	odo_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	odo_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.rsp    (cor_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpt_q       <= odo_pkg::CPT_RST;
			tire_q      <= odo_pkg::TIRE_RST;
			track_q     <= odo_pkg::TRACK_RST;
			state_q     <= S_IDLE;
			first_q     <= 1'b1;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			head_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					odo_pkg::REG_CPT:   cpt_q   <= cfg_data;
					odo_pkg::REG_TIRE:  tire_q  <= cfg_data;
					odo_pkg::REG_TRACK: track_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (md_req.start || cor_req.start)
				issued_q <= 1'b1;
			if (md_rsp.done || cor_rsp.done)
				issued_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						lc_q     <= left_count;
						rraw_q   <= right_count;
						period_q <= period_us;
						rst_q    <= restart;
						state_q  <= S_PREP;
					end
				end
				S_PREP: begin
					if (rst_q) begin
						head_q <= '0;
						x_q    <= '0;
						y_q    <= '0;
					end
					first_q  <= 1'b0;
					dl_q     <= odo_pkg::unwrap(lc_q, pl, cpt_q);
					dr_q     <= odo_pkg::unwrap(rc, pr, cpt_q);
					prev_l_q <= lc_q;
					prev_r_q <= rc;
					den_q    <= den_w;
					state_q  <= S_RL;
				end
				S_RL: begin
					if (den_q == '0) begin
						rl_q    <= '0;
						rr_q    <= '0;
						state_q <= S_VL;
					end else if (md_rsp.done) begin
						rl_q    <= odo_pkg::sat32(md_rsp.quot);
						state_q <= S_RR;
					end
				end
				S_RR: begin
					if (md_rsp.done) begin
						rr_q    <= odo_pkg::sat32(md_rsp.quot);
						state_q <= S_VL;
					end
				end
				S_VL: begin
					if (md_rsp.done) begin
						vl_q    <= odo_pkg::sat32(md_rsp.quot);
						state_q <= S_VR;
					end
				end
				S_VR: begin
					if (md_rsp.done) begin
						vr_q    <= odo_pkg::sat32(md_rsp.quot);
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					prod_q  <= prod_w;
					tden_q  <= tden_w;
					state_q <= S_DTH;
				end
				S_DTH: begin
					if (track_q == '0) begin
						dth_q   <= '0;
						state_q <= S_HEAD;
					end else if (md_rsp.done) begin
						dth_q   <= md_rsp.quot;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					hnew_q  <= odo_pkg::sat40(hsum);
					state_q <= S_S;
				end
				S_S: begin
					if (md_rsp.done) begin
						s_q     <= md_rsp.quot;
						a_q     <= md_rsp.quot;
						state_q <= big_turn ? S_MOD1 : S_MOD2;
					end
				end
				S_MOD1: begin
					if (md_rsp.done) begin
						r_q     <= red;
						state_q <= S_COR1;
					end
				end
				S_COR1: begin
					if (cor_rsp.done) begin
						si_q    <= cor_rsp.si;
						state_q <= S_A;
					end
				end
				S_A: begin
					// chord = arc * sin(h)/h
					if (md_rsp.done) begin
						a_q     <= md_rsp.quot;
						state_q <= S_MOD2;
					end
				end
				S_MOD2: begin
					if (md_rsp.done) begin
						r_q     <= red;
						state_q <= S_COR2;
					end
				end
				S_COR2: begin
					if (cor_rsp.done) begin
						co_q    <= cor_rsp.co;
						si_q    <= cor_rsp.si;
						state_q <= S_X;
					end
				end
				S_X: begin
					if (md_rsp.done) begin
						x_q     <= odo_pkg::sat48(xsum);
						state_q <= S_Y;
					end
				end
				S_Y: begin
					if (md_rsp.done) begin
						y_q     <= odo_pkg::sat48(ysum);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						head_q      <= hnew_q;
						o_rl_q      <= rl_q;
						o_rr_q      <= rr_q;
						o_vl_q      <= vl_q;
						o_vr_q      <= vr_q;
						o_head_q    <= hnew_q;
						o_x_q       <= x_q;
						o_y_q       <= y_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign left_wheel_rate  = o_rl_q;
	assign right_wheel_rate = o_rr_q;
	assign left_speed       = o_vl_q;
	assign right_speed      = o_vr_q;
	assign heading          = o_head_q;
	assign pos_x            = o_x_q;
	assign pos_y            = o_y_q;

	a_md_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |-> !md_rsp.busy)
		else $error("multiply-divide started while busy");

	a_cor_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cor_req.start |-> !cor_rsp.busy)
		else $error("cordic started while busy");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction taken while a sample is in flight");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PREP && rst_q) |=> (x_q == '0 && y_q == '0 && head_q == '0))
		else $error("restart did not clear the pose");

endmodule

>>> tb/sv/odometry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_checker
// Watches the sample, pose and register ports of the odometry core, keeps
// its own copy of geometry and pose state, predicts each pose and compares.
// ----------------------------------------------------------------------------
module odometry_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [odo_pkg::CNT_W-1:0]           cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [odo_pkg::CNT_W-1:0]           left_count,
	input  logic [odo_pkg::CNT_W-1:0]           right_count,
	input  logic [odo_pkg::PERIOD_W-1:0]        period_us,
	input  logic                                restart,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [odo_pkg::RATE_W-1:0]   left_wheel_rate,
	input  logic signed [odo_pkg::RATE_W-1:0]   right_wheel_rate,
	input  logic signed [odo_pkg::RATE_W-1:0]   left_speed,
	input  logic signed [odo_pkg::RATE_W-1:0]   right_speed,
	input  logic signed [odo_pkg::HEAD_W-1:0]   heading,
	input  logic signed [odo_pkg::POS_W-1:0]    pos_x,
	input  logic signed [odo_pkg::POS_W-1:0]    pos_y,
	output int                                  errors,
	output int                                  pending,
	output int                                  checked
);
	import odo_pkg::*;

	localparam int    STEPS      = CORDIC_STEPS_DEF;
	localparam longint RATE_K    = 64'sd411774832291;
	localparam longint HALF_PI   = 64'sd52707179;
	localparam longint FULL_TURN = 4 * HALF_PI;
	localparam longint GAIN      = 64'sd652032875;
	localparam longint TURN_MIN  = 64'sd131072;
	localparam longint unsigned QUOT_CAP = 64'h4000_0000_0000_0000;

	typedef struct packed {
		logic [RATE_W-1:0] lrate;
		logic [RATE_W-1:0] rrate;
		logic [RATE_W-1:0] lspd;
		logic [RATE_W-1:0] rspd;
		logic [HEAD_W-1:0] head;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
	} pose_t;

	const longint atan_tab[32] = '{843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
		524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

	pose_t  pose_q[$];
	longint cpt, tire, track;
	bit     first;
	longint last_l, last_r, head_acc, x_acc, y_acc;

	// round(a*b/c) half up, capped at 2^62
	function automatic longint unsigned scale_u(longint unsigned a, longint unsigned b,
			longint unsigned c);
		logic [127:0] p;
		logic [127:0] q;
		p = 128'(a) * 128'(b) + 128'(c / 2);
		q = p / 128'(c);
		return (q > 128'(QUOT_CAP)) ? QUOT_CAP : q[63:0];
	endfunction

	function automatic longint unsigned abs_u(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint scale_s(longint a, longint b, longint c);
		bit neg;
		longint unsigned q;
		neg = ((a < 0) != (b < 0)) ^ (c < 0);
		q = scale_u(abs_u(a), abs_u(b), abs_u(c));
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	function automatic longint fold_delta(longint cur, longint prv);
		longint d;
		d = cur - prv;
		if (cpt >= 2) begin
			if (d >= cpt / 2)
				d -= cpt;
			else if (d <= -(cpt / 2))
				d += cpt;
		end
		return d;
	endfunction

	// angle in 2^-25 rad -> cos/sin in Q30
	task automatic rotate(input longint ang, output longint co, output longint si);
		longint r, q, z, x, y, t;
		r = ang % FULL_TURN;
		if (r < 0)
			r += FULL_TURN;
		q = r / HALF_PI;
		z = (r - q * HALF_PI) * 32;
		x = GAIN;
		y = 0;
		for (int i = 0; i < STEPS && i < 32; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_tab[i];
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_tab[i];
			end
			x = t;
		end
		case (q & 3)
			0: begin co = x; si = y; end
			1: begin co = -y; si = x; end
			2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endtask

	task automatic predict_pose(input longint lc, input longint rraw, input longint per,
			input bit rst, output pose_t p);
		longint rc, den, dl, dr, rl, rr, vl, vr, dth, hnew, s, a, co, si;
		rc = (rraw == 0) ? 0 : ((cpt - rraw) & 64'hFFFF);
		den = cpt * per;
		rl = 0;
		rr = 0;
		dth = 0;
		if (rst) begin
			head_acc = 0;
			x_acc = 0;
			y_acc = 0;
			first = 1;
		end
		if (first) begin
			last_l = lc;
			last_r = rc;
			first = 0;
		end
		dl = fold_delta(lc, last_l);
		dr = fold_delta(rc, last_r);
		last_l = lc;
		last_r = rc;
		if (den != 0) begin
			rl = clamp(scale_s(dl, RATE_K, den), 32);
			rr = clamp(scale_s(dr, RATE_K, den), 32);
		end
		vl = clamp(scale_s(rl, tire, 131072), 32);
		vr = clamp(scale_s(rr, tire, 131072), 32);
		if (track != 0)
			dth = scale_s((vl - vr) * per, 64'sd1 <<< 24, track * 1000000);
		hnew = clamp(head_acc + dth, 40);
		s = scale_s(vl + vr, 8 * per, 1000000);
		a = s;
		if (dth >= TURN_MIN || dth <= -TURN_MIN) begin
			rotate(dth, co, si);
			a = scale_s(s, si, dth * 32);
		end
		rotate(head_acc + hnew, co, si);
		x_acc = clamp(x_acc + scale_s(a, co, 64'sd1 <<< 30), 48);
		y_acc = clamp(y_acc + scale_s(a, si, 64'sd1 <<< 30), 48);
		head_acc = hnew;
		p.lrate = rl[31:0];
		p.rrate = rr[31:0];
		p.lspd  = vl[31:0];
		p.rspd  = vr[31:0];
		p.head  = head_acc[39:0];
		p.x     = x_acc[47:0];
		p.y     = y_acc[47:0];
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("%0t mismatch pose %0d %s: expected %h actual %h",
					$time, checked, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pose_t p;
		if (!arst_n) begin
			cpt = CPT_RST;
			tire = TIRE_RST;
			track = TRACK_RST;
			first = 1;
			last_l = 0;
			last_r = 0;
			head_acc = 0;
			x_acc = 0;
			y_acc = 0;
			pose_q.delete();
			errors = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CPT:   cpt = cfg_data;
					REG_TIRE:  tire = cfg_data;
					REG_TRACK: track = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_pose(left_count, right_count, period_us, restart, p);
				pose_q.push_back(p);
			end
			if (out_valid && out_ready) begin
				if (pose_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t pose transaction with none expected", $time);
				end else begin
					p = pose_q.pop_front();
					check_field("left_wheel_rate", p.lrate, unsigned'(left_wheel_rate));
					check_field("right_wheel_rate", p.rrate, unsigned'(right_wheel_rate));
					check_field("left_speed", p.lspd, unsigned'(left_speed));
					check_field("right_speed", p.rspd, unsigned'(right_speed));
					check_field("heading", p.head, unsigned'(heading));
					check_field("pos_x", p.x, unsigned'(pos_x));
					check_field("pos_y", p.y, unsigned'(pos_y));
				end
				checked++;
			end
		end
		pending = pose_q.size();
	end

endmodule

>>> tb/sv/differential_drive_odometry_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_core_tb
// Drives encoder samples and geometry settings into the odometry core with
// random idling on both channels; the checker predicts and compares poses.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core_tb;
	import odo_pkg::*;

	localparam longint CYCLE_LIMIT = 20000000;
	localparam int     DRAIN       = 2000;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [1:0]                 cfg_index;
	logic [CNT_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [CNT_W-1:0]           left_count;
	logic [CNT_W-1:0]           right_count;
	logic [PERIOD_W-1:0]        period_us;
	logic                       restart;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [RATE_W-1:0]   left_wheel_rate;
	logic signed [RATE_W-1:0]   right_wheel_rate;
	logic signed [RATE_W-1:0]   left_speed;
	logic signed [RATE_W-1:0]   right_speed;
	logic signed [HEAD_W-1:0]   heading;
	logic signed [POS_W-1:0]    pos_x;
	logic signed [POS_W-1:0]    pos_y;

	int     errors, pending, checked;
	int     tx_idle_pct, rx_idle_pct, hold_left, sent;
	longint cycles = 0;
	logic [CNT_W-1:0] l_pos, r_pos;

	differential_drive_odometry_core dut (.*);

	odometry_checker chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d poses pending", cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls plus a single long hold-off
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 0;
				hold_left--;
			end else
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [CNT_W-1:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic drain;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send(input logic [15:0] lc, input logic [15:0] rc,
			input logic [19:0] per, input logic rst);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid    <= 1;
		left_count  <= lc;
		right_count <= rc;
		period_us   <= per;
		restart     <= rst;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	// mostly smooth wheel motion, some jumps, period mostly 0.5 to 2 ms with some extremes
	task automatic send_random;
		logic [19:0] per;
		int k;
		k = $urandom_range(99);
		if (k < 80) begin
			l_pos = l_pos + 16'($urandom_range(600) - 300);
			r_pos = r_pos + 16'($urandom_range(600) - 300);
		end else begin
			l_pos = 16'($urandom);
			r_pos = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
		end
		k = $urandom_range(99);
		if (k < 70)
			per = 20'($urandom_range(2000, 500));
		else if (k < 95)
			per = 20'($urandom_range(20'hFFFFF, 1));
		else
			per = ($urandom_range(1) == 1) ? 20'hFFFFF : 20'd1;
		send(l_pos, r_pos, per, $urandom_range(99) < 3);
	endtask

	task automatic set_geometry(input logic [15:0] c, input logic [15:0] t,
			input logic [15:0] w);
		in_valid <= 0;
		drain();
		@(negedge clk);
		reg_write(REG_CPT, c);
		reg_write(REG_TIRE, t);
		reg_write(REG_TRACK, w);
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_CPT;
		cfg_data = 0;
		in_valid = 0;
		left_count = 0;
		right_count = 0;
		period_us = 0;
		restart = 0;
		hold_left = 0;
		sent = 0;
		l_pos = 0;
		r_pos = 0;
		tx_idle_pct = 13;
		rx_idle_pct = 46;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: first sample, wrap, mirror of zero, extremes, restart
		send(16'd100, 16'd200, 20'd1000, 0);
		send(16'd100, 16'd200, 20'd1000, 0);
		send(16'd400, 16'd100, 20'd1000, 0);
		send(16'd65530, 16'd0, 20'd1000, 0);
		send(16'd5, 16'd65535, 20'd1000, 0);
		send(16'd8197, 16'd8192, 20'd1000, 0);
		send(16'd5, 16'd0, 20'd1000, 0);
		send(16'd3000, 16'd1000, 20'd1, 0);
		send(16'd0, 16'd9000, 20'd1, 0);
		send(16'd800, 16'd9100, 20'hFFFFF, 0);
		send(16'd900, 16'd9000, 20'd0, 0);
		send(16'd1200, 16'd8000, 20'd1000, 0);
		send(16'd1500, 16'd6000, 20'd1000, 1);
		send(16'd1600, 16'd6300, 20'd1000, 0);
		send(16'd65535, 16'd65535, 20'd500, 0);
		send(16'd0, 16'd1, 20'd500, 1);
		send(16'd7000, 16'd12000, 20'd2000, 0);
		send(16'd14000, 16'd3000, 20'd2000, 0);

		set_geometry(16'd4096, 16'd3000, 16'd9000);
		for (int i = 0; i < 300; i++) begin
			if (i == 150)
				hold_left = 6000;
			send_random();
		end

		// extreme geometry, min and max
		set_geometry(16'd2, 16'd65535, 16'd1);
		for (int i = 0; i < 60; i++)
			send_random();
		set_geometry(16'd65535, 16'd1, 16'd65535);
		for (int i = 0; i < 60; i++)
			send_random();
		set_geometry(16'd0, 16'd0, 16'd0);
		reg_write(2'd3, 16'hFFFF);
		for (int i = 0; i < 20; i++)
			send_random();
		set_geometry(16'd1, 16'd3456, 16'd8448);
		for (int i = 0; i < 20; i++)
			send_random();

		tx_idle_pct = 46;
		rx_idle_pct = 13;
		set_geometry(16'd1000, 16'd4000, 16'd12000);
		for (int i = 0; i < 260; i++)
			send_random();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_geometry(CPT_RST, TIRE_RST, TRACK_RST);
		for (int i = 0; i < 260; i++)
			send_random();

		in_valid <= 0;
		drain();
		repeat (DRAIN) @(negedge clk);
		$display("sent %0d samples over 8 geometry settings, %0d poses checked",
			sent, checked);
		$display("idling both ways, long output hold-off, mismatches: %0d", errors);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
